FILE: rtl/r2fft_pkg.sv
package r2fft_pkg;

   localparam int MaxLog2Points = 6;
   localparam int MaxPoints     = 1 << MaxLog2Points;
   localparam int SampleWidth   = 16;
   localparam int IntWidth      = 24;
   localparam int OutWidth      = 24;
   localparam int AddrWidth     = MaxLog2Points;
   localparam int WordWidth     = 2 * IntWidth;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = 2;

   localparam logic [0:0] CsrLog2Points = 1'b0;
   localparam logic [0:0] CsrInverse    = 1'b1;

   typedef logic signed [IntWidth-1:0] int_type;

   typedef struct packed {
      int_type re;
      int_type im;
   } cplx_type;

   // One loaded sample on its way from the front part to the back part.
   typedef struct packed {
      cplx_type                sample;
      logic [AddrWidth-1:0]    addr;
      logic                    frame_end;
      logic [2:0]              log2n;
      logic                    inverse;
   } load_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FLY_RD,
      ST_FLY_WAIT,
      ST_FLY_MUL,
      ST_FLY_WR,
      ST_OUT_RD,
      ST_OUT_WAIT
   } engine_state_type;

   // round(32768 * cos(2*pi*j/64)) for j = 0..16
   function automatic logic signed [17:0] quarter_cos(input logic [4:0] j);
      logic signed [17:0] v;
      case (j)
         5'd0:  v = 18'sd32768;
         5'd1:  v = 18'sd32610;
         5'd2:  v = 18'sd32138;
         5'd3:  v = 18'sd31357;
         5'd4:  v = 18'sd30274;
         5'd5:  v = 18'sd28899;
         5'd6:  v = 18'sd27246;
         5'd7:  v = 18'sd25330;
         5'd8:  v = 18'sd23170;
         5'd9:  v = 18'sd20788;
         5'd10: v = 18'sd18205;
         5'd11: v = 18'sd15447;
         5'd12: v = 18'sd12540;
         5'd13: v = 18'sd9512;
         5'd14: v = 18'sd6393;
         5'd15: v = 18'sd3212;
         default: v = 18'sd0;
      endcase
      return v;
   endfunction

   // cos(2*pi*j/64) in Q3.15
   function automatic logic signed [17:0] cos64(input logic [5:0] j);
      logic signed [17:0] v;
      if (j <= 6'd16)       v = quarter_cos(j[4:0]);
      else if (j <= 6'd32)  v = -quarter_cos(5'(6'd32 - j));
      else if (j <= 6'd48)  v = -quarter_cos(5'(j - 6'd32));
      else                  v = quarter_cos(5'(7'd64 - {1'b0, j}));
      return v;
   endfunction

   function automatic int_type sat_int(input logic signed [IntWidth+1:0] v);
      int_type r;
      if (v > $signed({3'b000, {(IntWidth-1){1'b1}}}))
         r = {1'b0, {(IntWidth-1){1'b1}}};
      else if (v < $signed({3'b111, {(IntWidth-1){1'b0}}}))
         r = {1'b1, {(IntWidth-1){1'b0}}};
      else
         r = v[IntWidth-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/r2fft_ram.sv
module r2fft_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/r2fft_front.sv
module r2fft_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [r2fft_pkg::SampleWidth-1:0] req_sample_re,
   input  logic signed [r2fft_pkg::SampleWidth-1:0] req_sample_im,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [2:0]                            csr_data,
   output logic                                  q_valid,
   output r2fft_pkg::load_type                   q_word,
   input  logic                                  q_take
);
   import r2fft_pkg::*;

   logic [2:0]               log2_ff, log2_in;
   logic                     inv_ff, inv_in;
   logic [6:0]               count_ff, count_in;
   load_type                 slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wp_ff, rp_ff;
   logic [QueuePtrWidth:0]   fill_ff, fill_in;
   logic [2:0]               eff_log2;
   logic [6:0]               npoints;
   logic                     accept;
   load_type                 word;

   always_comb begin
      eff_log2 = log2_ff;
      if (log2_ff == 3'd0) eff_log2 = 3'd1;
      if (log2_ff > 3'(MaxLog2Points)) eff_log2 = 3'(MaxLog2Points);
      npoints = 7'd1 << eff_log2;
   end

   assign req_full = (fill_ff == (QueuePtrWidth+1)'(QueueDepth));
   assign accept   = req_push && !req_full;

   always_comb begin
      word.sample.re = int_type'(req_sample_re);
      word.sample.im = int_type'(req_sample_im);
      word.addr      = count_ff[AddrWidth-1:0];
      word.frame_end = (count_ff + 7'd1 == npoints);
      word.log2n     = eff_log2;
      word.inverse   = inv_ff;
   end

   always_comb begin
      log2_in  = log2_ff;
      inv_in   = inv_ff;
      count_in = count_ff;
      if (accept) count_in = word.frame_end ? 7'd0 : count_ff + 7'd1;
      if (csr_write) begin
         count_in = 7'd0;
         if (csr_index == CsrLog2Points) log2_in = csr_data;
         else                            inv_in  = csr_data[0];
      end
      fill_in = fill_ff + (QueuePtrWidth+1)'(accept) - (QueuePtrWidth+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff  <= 3'(MaxLog2Points);
         inv_ff   <= 1'b0;
         count_ff <= 7'd0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         log2_ff  <= log2_in;
         inv_ff   <= inv_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         if (accept) wp_ff <= wp_ff + 1'b1;
         if (q_take) rp_ff <= rp_ff + 1'b1;
      end
      if (accept) slot_ff[wp_ff] <= word;
   end

   assign q_valid = (fill_ff != '0);
   assign q_word  = slot_ff[rp_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !(fill_ff > (QueuePtrWidth+1)'(QueueDepth)))
      else $error("load queue overfilled");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      q_take |-> q_valid)
      else $error("take from empty load queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < npoints || $past(csr_write))
      else $error("load count out of range");

endmodule

FILE: rtl/r2fft_engine.sv
module r2fft_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  r2fft_pkg::load_type                 q_word,
   output logic                                q_take,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [r2fft_pkg::OutWidth-1:0] rsp_result_re,
   output logic signed [r2fft_pkg::OutWidth-1:0] rsp_result_im,
   output logic [5:0]                          rsp_bin_index,
   output logic                                rsp_last_bin
);
   import r2fft_pkg::*;

   engine_state_type     state_ff, state_in;
   logic                 bank_ff, bank_in;       // bank holding the current data
   logic [2:0]           log2_ff, log2_in;
   logic                 inv_ff, inv_in;
   logic [2:0]           stage_ff, stage_in;     // m - 1
   logic [AddrWidth-1:0] pos_ff, pos_in;         // butterfly or bin counter
   logic                 half_ff, half_in;       // 0 reads a, 1 reads b
   cplx_type             a_ff, a_in;
   cplx_type             b_ff, b_in;
   logic signed [17:0]   wr_ff, wr_in, wi_ff, wi_in;
   logic signed [41:0]   pr_ff, pr_in, pi_ff, pi_in;
   logic                 wsel_ff, wsel_in;       // second write of a butterfly
   // output register stage
   logic                 ov_ff, ov_in;
   cplx_type             ov_data_ff;
   logic [5:0]           ov_idx_ff;
   logic                 ov_last_ff;

   logic [AddrWidth-1:0] rd_addr, wr_addr, dm, kk, ii, a_addr, b_addr, o_addr, half_n;
   logic [AddrWidth-1:0] npm1;
   logic [5:0]           twj;
   logic                 we0, we1;
   logic [WordWidth-1:0] wdata, rd0, rd1;
   cplx_type             rdc;
   logic signed [IntWidth+1:0] sum_r, sum_i, dif_r, dif_i;
   logic signed [41:0]   rr, ri;
   logic signed [17:0]   ws;
   logic [IntWidth-1:0]  shr_re, shr_im;

   r2fft_ram #(.Width(WordWidth), .Depth(MaxPoints)) u_bank0 (
      .clock(clock), .wr_en(we0), .wr_addr(wr_addr), .wr_data(wdata),
      .rd_addr(rd_addr), .rd_data(rd0));
   r2fft_ram #(.Width(WordWidth), .Depth(MaxPoints)) u_bank1 (
      .clock(clock), .wr_en(we1), .wr_addr(wr_addr), .wr_data(wdata),
      .rd_addr(rd_addr), .rd_data(rd1));

   assign rdc    = bank_ff ? cplx_type'(rd1) : cplx_type'(rd0);
   assign npm1   = AddrWidth'((7'd1 << log2_ff) - 7'd1);
   assign half_n = AddrWidth'(7'd1 << (log2_ff - 3'd1));
   // butterfly pos = i * groups + k, groups = 2^stage
   assign dm     = AddrWidth'(7'd1 << (log2_ff - 3'd1 - stage_ff));
   assign kk     = pos_ff & AddrWidth'((7'd1 << stage_ff) - 7'd1);
   assign ii     = pos_ff >> stage_ff;
   assign a_addr = AddrWidth'(ii + ((kk * dm) << 1));
   assign b_addr = a_addr + dm;
   assign o_addr = AddrWidth'(ii + kk * dm);
   assign twj    = 6'((kk * dm) << (3'(MaxLog2Points) - log2_ff));

   always_comb begin
      sum_r = (IntWidth+2)'(a_ff.re) + (IntWidth+2)'($signed(pr_ff[IntWidth-1:0]));
      sum_i = (IntWidth+2)'(a_ff.im) + (IntWidth+2)'($signed(pi_ff[IntWidth-1:0]));
      dif_r = (IntWidth+2)'(a_ff.re) - (IntWidth+2)'($signed(pr_ff[IntWidth-1:0]));
      dif_i = (IntWidth+2)'(a_ff.im) - (IntWidth+2)'($signed(pi_ff[IntWidth-1:0]));
   end

   always_comb begin
      logic signed [42:0] raw_r, raw_i;
      raw_r = 43'(b_ff.re) * 43'(wr_ff) - 43'(b_ff.im) * 43'(wi_ff) + 43'sd16384;
      raw_i = 43'(b_ff.re) * 43'(wi_ff) + 43'(b_ff.im) * 43'(wr_ff) + 43'sd16384;
      rr = 42'(raw_r >>> 15);
      ri = 42'(raw_i >>> 15);
   end

   always_comb begin
      shr_re = rdc.re >>> (inv_ff ? log2_ff : 3'd0);
      shr_im = rdc.im >>> (inv_ff ? log2_ff : 3'd0);
   end

   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      log2_in  = log2_ff;
      inv_in   = inv_ff;
      stage_in = stage_ff;
      pos_in   = pos_ff;
      half_in  = half_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      wr_in    = wr_ff;
      wi_in    = wi_ff;
      pr_in    = pr_ff;
      pi_in    = pi_ff;
      wsel_in  = wsel_ff;
      ov_in    = ov_ff && !rsp_pop;
      q_take   = 1'b0;
      rd_addr  = a_addr;
      wr_addr  = q_word.addr;
      wdata    = q_word.sample;
      we0      = 1'b0;
      we1      = 1'b0;
      ws       = cos64(twj + 6'd48);
      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (bank_ff) we1 = 1'b1; else we0 = 1'b1;
               if (q_word.frame_end) begin
                  log2_in  = q_word.log2n;
                  inv_in   = q_word.inverse;
                  stage_in = 3'd0;
                  pos_in   = '0;
                  half_in  = 1'b0;
                  state_in = ST_FLY_RD;
               end
            end
         end
         ST_FLY_RD: begin
            rd_addr  = half_ff ? b_addr : a_addr;
            state_in = ST_FLY_WAIT;
         end
         ST_FLY_WAIT: begin
            if (!half_ff) begin
               a_in     = rdc;
               half_in  = 1'b1;
               state_in = ST_FLY_RD;
            end else begin
               b_in     = rdc;
               wr_in    = cos64(twj);
               wi_in    = inv_ff ? ws : -ws;
               half_in  = 1'b0;
               state_in = ST_FLY_MUL;
            end
         end
         ST_FLY_MUL: begin
            pr_in    = 42'(sat_int((IntWidth+2)'(rr > 42'sd33554431 ? 42'sd33554431 :
                                   rr < -42'sd33554432 ? -42'sd33554432 : rr)));
            pi_in    = 42'(sat_int((IntWidth+2)'(ri > 42'sd33554431 ? 42'sd33554431 :
                                   ri < -42'sd33554432 ? -42'sd33554432 : ri)));
            wsel_in  = 1'b0;
            state_in = ST_FLY_WR;
         end
         ST_FLY_WR: begin
            wr_addr = wsel_ff ? o_addr + half_n : o_addr;
            wdata   = wsel_ff ? {sat_int(dif_r), sat_int(dif_i)}
                              : {sat_int(sum_r), sat_int(sum_i)};
            if (bank_ff) we0 = 1'b1; else we1 = 1'b1;
            if (!wsel_ff) begin
               wsel_in = 1'b1;
            end else if (pos_ff == (npm1 >> 1)) begin
               pos_in  = '0;
               bank_in = !bank_ff;
               if (stage_ff == log2_ff - 3'd1) begin
                  state_in = ST_OUT_RD;
               end else begin
                  stage_in = stage_ff + 3'd1;
                  state_in = ST_FLY_RD;
               end
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_FLY_RD;
            end
         end
         ST_OUT_RD: begin
            rd_addr = pos_ff;
            if (!ov_in) begin
               state_in = ST_OUT_WAIT;
            end
         end
         ST_OUT_WAIT: begin
            ov_in = 1'b1;
            if (pos_ff == npm1) begin
               pos_in   = '0;
               state_in = ST_LOAD;
            end else begin
               pos_in   = pos_ff + 1'b1;
               state_in = ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         bank_ff  <= 1'b0;
         ov_ff    <= 1'b0;
         pos_ff   <= '0;
         half_ff  <= 1'b0;
         wsel_ff  <= 1'b0;
         stage_ff <= 3'd0;
         log2_ff  <= 3'(MaxLog2Points);
         inv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         ov_ff    <= ov_in;
         pos_ff   <= pos_in;
         half_ff  <= half_in;
         wsel_ff  <= wsel_in;
         stage_ff <= stage_in;
         log2_ff  <= log2_in;
         inv_ff   <= inv_in;
      end
      a_ff  <= a_in;
      b_ff  <= b_in;
      wr_ff <= wr_in;
      wi_ff <= wi_in;
      pr_ff <= pr_in;
      pi_ff <= pi_in;
      if (state_ff == ST_OUT_WAIT) begin
         ov_data_ff.re <= shr_re;
         ov_data_ff.im <= shr_im;
         ov_idx_ff     <= 6'(pos_ff);
         ov_last_ff    <= (pos_ff == npm1);
      end
   end

   assign rsp_empty     = !ov_ff;
   assign rsp_result_re = ov_data_ff.re;
   assign rsp_result_im = ov_data_ff.im;
   assign rsp_bin_index = ov_idx_ff;
   assign rsp_last_bin  = ov_last_ff;

   a_take_in_load: assert property (@(posedge clock) disable iff (reset)
      q_take |-> state_ff == ST_LOAD)
      else $error("load word taken outside load state");
   a_out_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT_WAIT |-> $past(state_ff) == ST_OUT_RD && !ov_ff)
      else $error("output read issued while result register full");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp_pop |=> ov_ff && $stable(ov_idx_ff))
      else $error("waiting result lost");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(we0 && we1))
      else $error("both banks written at once");

endmodule

FILE: rtl/radix2_fft_ifft.sv
// Radix-2 Stockham FFT / inverse FFT of 2, 4, ... 64 complex points.
// Input channel: one complex Q1.15 sample word is taken per req_push while
// req_full is low, in index order. Once 2^log2_points words have arrived the
// frame is transformed and 2^log2_points result words leave on the result
// channel in natural bin order, rsp_last_bin marking the final one.
// Configuration: csr_write with csr_index 0 sets log2_points (0 acts as 1,
// above 6 acts as 6), index 1 sets inverse. Any write drops a partial frame.
// Loading takes one word per cycle while words are queued; the transform
// then runs log2_points * 2^(log2_points-1) butterflies on a single shared
// butterfly unit (two reads through the registered RAM, multiply, two
// writes), and the result drain reads the bins one at a time, waiting while
// the result register is full. The frame time is set mostly by the
// butterfly unit.
// A four-word queue between the loader and the engine lets the source
// push ahead while the engine is still draining.
// Reset clears the frame count, the queue and the result register and sets
// the length to 64 forward. When the receiver holds pop low the result
// register stays full, the engine waits, and req_full rises once the queue fills.
module radix2_fft_ifft (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [r2fft_pkg::SampleWidth-1:0] req_sample_re,
   input  logic signed [r2fft_pkg::SampleWidth-1:0] req_sample_im,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [r2fft_pkg::OutWidth-1:0] rsp_result_re,
   output logic signed [r2fft_pkg::OutWidth-1:0] rsp_result_im,
   output logic [5:0]                            rsp_bin_index,
   output logic                                  rsp_last_bin,
   input  logic                                  csr_write,
   input  logic                                  csr_index,
   input  logic [2:0]                            csr_data
);
   import r2fft_pkg::*;

   logic     q_valid;
   logic     q_take;
   load_type q_word;

   // The front part counts the frame and tags each word with its slot.
   r2fft_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sample_re(req_sample_re), .req_sample_im(req_sample_im),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .q_valid(q_valid), .q_word(q_word), .q_take(q_take));

   // The engine stores the frame, runs the stages and drains the bins.
   r2fft_engine u_engine (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_word(q_word), .q_take(q_take),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_result_re(rsp_result_re), .rsp_result_im(rsp_result_im),
      .rsp_bin_index(rsp_bin_index), .rsp_last_bin(rsp_last_bin));

endmodule
